FILE: hdl/differential_drive_odometry_unit_assert.svh
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Shared concurrent check templates, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH

// same-cycle implication
`define ODO_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ODO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/odo_pkg.sv
// ----------------------------------------------------------------------------
// Odometry package
// Field types, datapath widths, angle table and sequencer codes.
// ----------------------------------------------------------------------------
package odo_pkg;

  localparam int DRV_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int POS_W      = 32;
  localparam int HEAD_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int ROT_W  = 34;
  localparam int MA_W   = 34;
  localparam int MB_W   = 18;
  localparam int MP_W   = MA_W + MB_W;
  localparam int LO_W   = 17;
  localparam int ACC_W  = MP_W + LO_W;
  localparam int FRAC_SH = 44;
  localparam int ATAN_IDX_W = 5;

  localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) <<< (FRAC_SH - 1);

  typedef logic signed [DRV_W-1:0]  drive_t;
  typedef logic [GAIN_W-1:0]        gain_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic [HEAD_W-1:0]        head_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]    cfg_data_t;
  typedef logic signed [ROT_W-1:0]  rot_t;

  localparam cfg_idx_t REG_TURN_GAIN = cfg_idx_t'(0);
  localparam cfg_idx_t REG_MOVE_GAIN = cfg_idx_t'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_TURN, S_MOVE, S_ROT, S_XLO, S_XHI, S_YLO, S_YHI, S_YACC, S_YUPD, S_POST
  } state_t;

  typedef enum logic [2:0] {
    MSEL_TURN, MSEL_MOVE, MSEL_CLO, MSEL_CHI, MSEL_SLO, MSEL_SHI
  } msel_t;

  typedef struct packed {
    logic  in_ready;
    logic  mul_en;
    msel_t msel;
    logic  rot_start;
    logic  out_load;
  } ctrl_t;

  function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/odo_if.sv
// ----------------------------------------------------------------------------
// Odometry channel interfaces
// Drive command, pose result and register write channels.
// ----------------------------------------------------------------------------
interface odo_in_if;
  logic            valid;
  logic            ready;
  odo_pkg::drive_t left_drive;
  odo_pkg::drive_t right_drive;
  modport source (output valid, output left_drive, output right_drive, input ready);
  modport sink   (input valid, input left_drive, input right_drive, output ready);
endinterface

interface odo_out_if;
  logic           valid;
  logic           ready;
  odo_pkg::pos_t  pos_x;
  odo_pkg::pos_t  pos_y;
  odo_pkg::head_t heading;
  modport source (output valid, output pos_x, output pos_y, output heading, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

interface odo_cfg_if;
  logic               valid;
  logic               ready;
  odo_pkg::cfg_idx_t  index;
  odo_pkg::cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/odo_mul.sv
// ----------------------------------------------------------------------------
// Odometry shared multiplier
// Signed 34 x 18 product, registered, updated only when enabled.
// ----------------------------------------------------------------------------
module odo_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [odo_pkg::MA_W-1:0]     a,
  input  logic signed [odo_pkg::MB_W-1:0]     b,
  output logic signed [odo_pkg::MP_W-1:0]     p_r
);
  import odo_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= MP_W'(a) * MP_W'(b);
    end
  end

endmodule

FILE: hdl/odo_cordic.sv
// ----------------------------------------------------------------------------
// Odometry CORDIC rotator
// Iterative cosine and sine of a binary angle, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module odo_cordic #(
  parameter int STEPS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  odo_pkg::head_t angle,
  output logic           done_r,
  output odo_pkg::rot_t  cos_r,
  output odo_pkg::rot_t  sin_r
);
  import odo_pkg::*;

  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic             run_r;
  logic             fix_r;
  logic             flip_r;
  logic [CNT_W-1:0] i_r;
  rot_t             z_r;
  rot_t             xs;
  rot_t             ys;
  rot_t             at;
  head_t            shifted;
  logic             flip;
  head_t            a_adj;

  assign shifted = angle + 16'h4000;
  assign flip    = shifted[HEAD_W-1];
  assign a_adj   = {angle[HEAD_W-1] ^ flip, angle[HEAD_W-2:0]};
  assign xs      = cos_r >>> i_r;
  assign ys      = sin_r >>> i_r;
  assign at      = rot_t'({2'b00, atan_turn(ATAN_IDX_W'(i_r))});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && i_r == LAST) begin
        run_r <= 1'b0;
        fix_r <= 1'b1;
      end else if (fix_r) begin
        fix_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cos_r  <= CORDIC_GAIN;
      sin_r  <= '0;
      z_r    <= rot_t'(signed'({a_adj, 16'h0000}));
      flip_r <= flip;
      i_r    <= '0;
    end else if (run_r) begin
      if (!z_r[ROT_W-1]) begin
        cos_r <= cos_r - ys;
        sin_r <= sin_r + xs;
        z_r   <= z_r - at;
      end else begin
        cos_r <= cos_r + ys;
        sin_r <= sin_r - xs;
        z_r   <= z_r + at;
      end
      i_r <= i_r + 1'b1;
    end else if (fix_r && flip_r) begin
      cos_r <= -cos_r;
      sin_r <= -sin_r;
    end
  end

endmodule

FILE: hdl/differential_drive_odometry_unit.sv
// A new beat is taken only in idle, so pose updates do not overlap: each waits for
// the iterative CORDIC rotator and the shared multiplier's six passes.
// A finished pose waits in the output register while the next beat enters.
// Reset: synchronous active-low; pose clears to zero, gains to 1000 / 1311.
// ----------------------------------------------------------------------------
// Differential drive odometry unit
// Dead-reckoning pose update per control tick with saturating position.
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_unit_assert.svh"

module differential_drive_odometry_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  odo_in_if.sink     in_ch,
  odo_out_if.source  out_ch,
  odo_cfg_if.sink    cfg_ch
);
  import odo_pkg::*;

  state_t state_r, state_nxt;
  ctrl_t  ctrl;

  gain_t  turn_gain_r;
  gain_t  move_gain_r;
  pos_t   x_r;
  pos_t   y_r;
  head_t  heading_r;

  logic signed [DRV_W:0]   diff_r;
  logic signed [DRV_W:0]   sum_r;
  logic signed [MA_W-1:0]  m_r;
  logic signed [ACC_W-1:0] acc_r;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MP_W-1:0]  mul_p;

  logic  rot_done;
  rot_t  cos_v;
  rot_t  sin_v;

  logic signed [MP_W-1:0]  turn_rnd;
  head_t                   heading_new;
  logic signed [ACC_W-1:0] hi_term;
  logic signed [ACC_W-FRAC_SH-1:0] delta;
  logic signed [POS_W:0]   x_sum;
  logic signed [POS_W:0]   y_sum;

  logic  out_valid_r;
  pos_t  out_x_r;
  pos_t  out_y_r;
  head_t out_head_r;
  logic  out_free;
  logic  in_fire;
  logic  cfg_fire;

  assign in_fire  = in_ch.valid && ctrl.in_ready;
  assign cfg_fire = cfg_ch.valid;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready    = ctrl.in_ready;
  assign cfg_ch.ready   = 1'b1;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.pos_x   = out_x_r;
  assign out_ch.pos_y   = out_y_r;
  assign out_ch.heading = out_head_r;

  assign turn_rnd    = mul_p + MP_W'(8192);
  assign heading_new = heading_r + turn_rnd[29:14];
  assign hi_term     = {mul_p, {LO_W{1'b0}}};
  assign delta       = acc_r[ACC_W-1:FRAC_SH];
  assign x_sum       = {x_r[POS_W-1], x_r} + (POS_W+1)'(delta);
  assign y_sum       = {y_r[POS_W-1], y_r} - (POS_W+1)'(delta);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_TURN;
      S_TURN:  state_nxt = S_MOVE;
      S_MOVE:  state_nxt = S_ROT;
      S_ROT:   if (rot_done) state_nxt = S_XLO;
      S_XLO:   state_nxt = S_XHI;
      S_XHI:   state_nxt = S_YLO;
      S_YLO:   state_nxt = S_YHI;
      S_YHI:   state_nxt = S_YACC;
      S_YACC:  state_nxt = S_YUPD;
      S_YUPD:  state_nxt = S_POST;
      S_POST:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '{in_ready: 1'b0, mul_en: 1'b0, msel: MSEL_TURN, rot_start: 1'b0,
             out_load: 1'b0};
    case (state_r)
      S_IDLE:  ctrl.in_ready = 1'b1;
      S_TURN:  begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_TURN;
      end
      S_MOVE:  begin
        ctrl.mul_en    = 1'b1;
        ctrl.msel      = MSEL_MOVE;
        ctrl.rot_start = 1'b1;
      end
      S_XLO:   begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_CLO;
      end
      S_XHI:   begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_CHI;
      end
      S_YLO:   begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_SLO;
      end
      S_YHI:   begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_SHI;
      end
      S_POST:  ctrl.out_load = out_free;
      default: ctrl.in_ready = 1'b0;
    endcase
  end

  always_comb begin
    case (ctrl.msel)
      MSEL_TURN: begin
        mul_a = MA_W'(diff_r);
        mul_b = signed'({2'b00, turn_gain_r});
      end
      MSEL_MOVE: begin
        mul_a = MA_W'(sum_r);
        mul_b = signed'({2'b00, move_gain_r});
      end
      MSEL_CLO: begin
        mul_a = m_r;
        mul_b = signed'({1'b0, cos_v[LO_W-1:0]});
      end
      MSEL_CHI: begin
        mul_a = m_r;
        mul_b = MB_W'(signed'(cos_v[ROT_W-1:LO_W]));
      end
      MSEL_SLO: begin
        mul_a = m_r;
        mul_b = signed'({1'b0, sin_v[LO_W-1:0]});
      end
      MSEL_SHI: begin
        mul_a = m_r;
        mul_b = MB_W'(signed'(sin_v[ROT_W-1:LO_W]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  odo_mul u_mul (
    .clk (clk),
    .en  (ctrl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  odo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctrl.rot_start),
    .angle  (heading_new + 16'h4000),
    .done_r (rot_done),
    .cos_r  (cos_v),
    .sin_r  (sin_v)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      turn_gain_r <= 16'd1000;
      move_gain_r <= 16'd1311;
      x_r         <= '0;
      y_r         <= '0;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        case (cfg_ch.index)
          REG_TURN_GAIN: turn_gain_r <= cfg_ch.data;
          REG_MOVE_GAIN: move_gain_r <= cfg_ch.data;
          default:       turn_gain_r <= turn_gain_r;
        endcase
      end
      if (state_r == S_MOVE) begin
        heading_r <= heading_new;
      end
      if (state_r == S_YHI) begin
        if (x_sum[POS_W] != x_sum[POS_W-1]) begin
          x_r <= x_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
          x_r <= x_sum[POS_W-1:0];
        end
      end
      if (state_r == S_YUPD) begin
        if (y_sum[POS_W] != y_sum[POS_W-1]) begin
          y_r <= y_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
          y_r <= y_sum[POS_W-1:0];
        end
      end
      if (ctrl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      diff_r <= (DRV_W+1)'(in_ch.right_drive) - (DRV_W+1)'(in_ch.left_drive);
      sum_r  <= (DRV_W+1)'(in_ch.right_drive) + (DRV_W+1)'(in_ch.left_drive);
    end
    if (state_r == S_ROT) begin
      m_r <= mul_p[MA_W-1:0];
    end
    case (state_r)
      S_XHI, S_YHI: acc_r <= ACC_W'(mul_p) + ACC_RND;
      S_YLO, S_YACC: acc_r <= acc_r + hi_term;
      default: acc_r <= acc_r;
    endcase
    if (ctrl.out_load) begin
      out_x_r    <= x_r;
      out_y_r    <= y_r;
      out_head_r <= heading_r;
    end
  end

  `ODO_ASSERT_NEXT(a_accept_starts, in_ch.valid && in_ch.ready, state_r == S_TURN, "beat accepted but sequencer did not start")
  `ODO_ASSERT_SAME(a_rot_done_in_rot, rot_done, state_r == S_ROT, "rotator finished outside rotate phase")
  `ODO_ASSERT_NEXT(a_post_loads, state_r == S_POST && out_free, out_valid_r && state_r == S_IDLE, "finished pose not presented")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Odometry unit testbench
// Drives motor command beats in bursts with gaps and stalls the pose channel.
// A local dead-reckoning predictor computes each expected pose, and the
// monitor checks every pose beat against it. Register writes happen only while
// the unit is idle. One stretch runs with no gaps and no stalls.
// ----------------------------------------------------------------------------
module testbench;
  import odo_pkg::*;

  localparam int       CORDIC_STEPS  = 16;
  localparam longint   CORDIC_K      = 64'sd652032874;
  localparam cfg_idx_t REG_NONE_NEAR = cfg_idx_t'(2);
  localparam cfg_idx_t REG_NONE_TOP  = cfg_idx_t'(255);

  localparam longint ATAN_TURNS [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    drive_t left;
    drive_t right;
  } tick_t;

  typedef struct {
    pos_t  x;
    pos_t  y;
    head_t heading;
  } pose_t;

  logic clk;
  logic rst_n;

  odo_in_if  in_bus ();
  odo_out_if out_bus ();
  odo_cfg_if cfg_bus ();

  differential_drive_odometry_unit #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  tick_t tick_q [$];
  pose_t pose_q [$];
  int    ticks_queued = 0;
  int    ticks_taken  = 0;
  int    pose_errors  = 0;
  logic  in_fire;
  logic  cfg_fire;
  logic  no_idle = 1'b0;

  gain_t  odo_turn_gain;
  gain_t  odo_move_gain;
  pos_t   odo_x;
  pos_t   odo_y;
  head_t  odo_heading;

  int burst_left = 1;
  int gap_left   = 0;
  int rx_cyc     = 0;
  int rx_mode    = 0;
  logic [15:0] rx_pattern = 16'hFFFF;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = ~clk;
  end

  function automatic pos_t sat_pos(input longint v);
    if (v > 64'sd2147483647) return pos_t'(32'sh7FFF_FFFF);
    if (v < -64'sd2147483648) return pos_t'(32'sh8000_0000);
    return pos_t'(v);
  endfunction

  task automatic advance_pose(input drive_t l, input drive_t r);
    longint      turn, mv, cx, cy, cz, xs, ys, dx, dy;
    logic [31:0] ang;
    logic        flip;
    pose_t       p;
    turn = ((longint'(r) - longint'(l)) * longint'(odo_turn_gain) + 64'sd8192) >>> 14;
    odo_heading = odo_heading + head_t'(turn);
    ang = {head_t'(odo_heading + 16'd16384), 16'h0000};
    flip = (ang + 32'h4000_0000) >= 32'h8000_0000;
    if (flip) ang = ang - 32'h8000_0000;
    cz = longint'(signed'(ang));
    cx = CORDIC_K;
    cy = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cz >= 0) begin
        cx = cx - ys;
        cy = cy + xs;
        cz = cz - ATAN_TURNS[i];
      end else begin
        cx = cx + ys;
        cy = cy - xs;
        cz = cz + ATAN_TURNS[i];
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    mv = (longint'(l) + longint'(r)) * longint'(odo_move_gain);
    dx = (mv * cx + (longint'(1) << 43)) >>> 44;
    dy = (mv * cy + (longint'(1) << 43)) >>> 44;
    odo_x = sat_pos(longint'(odo_x) + dx);
    odo_y = sat_pos(longint'(odo_y) - dy);
    p.x = odo_x;
    p.y = odo_y;
    p.heading = odo_heading;
    pose_q.push_back(p);
  endtask

  // prediction and checking, sampled at the rising edge
  always @(posedge clk) begin : monitor
    pose_t e;
    if (!rst_n) begin
      in_fire       <= 1'b0;
      cfg_fire      <= 1'b0;
      odo_turn_gain = 16'd1000;
      odo_move_gain = 16'd1311;
      odo_x         = '0;
      odo_y         = '0;
      odo_heading   = '0;
    end else begin
      in_fire  <= in_bus.valid && in_bus.ready;
      cfg_fire <= cfg_bus.valid && cfg_bus.ready;
      if (cfg_bus.valid && cfg_bus.ready) begin
        if (cfg_bus.index == REG_TURN_GAIN) odo_turn_gain = cfg_bus.data;
        else if (cfg_bus.index == REG_MOVE_GAIN) odo_move_gain = cfg_bus.data;
      end
      if (in_bus.valid && in_bus.ready) begin
        advance_pose(in_bus.left_drive, in_bus.right_drive);
        ticks_taken++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (pose_q.size() == 0) begin
          pose_errors++;
          if (pose_errors <= 10)
            $display("unexpected pose beat: x=%0d y=%0d h=%0d",
                     out_bus.pos_x, out_bus.pos_y, out_bus.heading);
        end else begin
          e = pose_q.pop_front();
          if (out_bus.pos_x !== e.x || out_bus.pos_y !== e.y ||
              out_bus.heading !== e.heading) begin
            pose_errors++;
            if (pose_errors <= 10)
              $display("pose mismatch: exp x=%0d y=%0d h=%0d got x=%0d y=%0d h=%0d",
                       e.x, e.y, e.heading,
                       out_bus.pos_x, out_bus.pos_y, out_bus.heading);
          end
        end
      end
    end
  end

  // command driver: bursts of beats separated by random gaps
  always @(negedge clk) begin : driver
    tick_t t;
    if (in_fire || !in_bus.valid) begin
      if (!no_idle && gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        t = tick_q.pop_front();
        in_bus.valid       <= 1'b1;
        in_bus.left_drive  <= t.left;
        in_bus.right_drive <= t.right;
        burst_left--;
        if (!no_idle && burst_left <= 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // pose receiver: randomly switches among always-ready, random and patterned stall modes
  always @(negedge clk) begin
    rx_cyc++;
    if (no_idle) begin
      out_bus.ready <= 1'b1;
    end else begin
      if (rx_cyc % 256 == 0) begin
        rx_mode    = $urandom_range(0, 2);
        rx_pattern = 16'($urandom) | 16'h0001;
      end
      case (rx_mode)
        0:       out_bus.ready <= 1'b1;
        1:       out_bus.ready <= 1'($urandom_range(0, 1));
        default: out_bus.ready <= rx_pattern[rx_cyc % 16];
      endcase
    end
  end

  task automatic queue_tick(input drive_t l, input drive_t r);
    tick_t t;
    t.left  = l;
    t.right = r;
    tick_q.push_back(t);
    ticks_queued++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (ticks_taken != ticks_queued || pose_q.size() != 0);
  endtask

  task automatic next_setting(input gain_t turn, input gain_t move);
    wait_drained();
    write_reg(REG_TURN_GAIN, turn);
    write_reg(REG_MOVE_GAIN, move);
  endtask

  function automatic gain_t pick_gain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return gain_t'($urandom);
    endcase
  endfunction

  function automatic drive_t pick_drive();
    if ($urandom_range(0, 4) == 0) return drive_t'($urandom);
    return drive_t'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  initial begin
    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.left_drive  = '0;
    in_bus.right_drive = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset gains: extremes of both drives
    queue_tick(0, 0);
    queue_tick(16384, 16384);
    queue_tick(-16384, -16384);
    queue_tick(16384, -16384);
    queue_tick(-16384, 16384);
    queue_tick(32767, -32768);
    queue_tick(-32768, 32767);
    queue_tick(32767, 32767);
    queue_tick(-32768, -32768);
    queue_tick(1, -1);

    // quarter-turn steps through every quadrant; unknown registers ignored
    next_setting(16384, 65535);
    write_reg(REG_NONE_NEAR, '1);
    write_reg(REG_NONE_TOP, '0);
    repeat (4) queue_tick(0, 16384);
    queue_tick(8192, -8192);
    queue_tick(16384, 16384);
    queue_tick(-16384, -16383);

    // zero gains hold the pose
    next_setting(0, 0);
    queue_tick(32767, -32768);
    queue_tick(-32768, 32767);
    queue_tick(16384, 16384);

    // heading wraps past a full turn
    next_setting(65535, 0);
    queue_tick(-32768, 32767);
    queue_tick(32767, -32768);
    next_setting(65535, 65535);
    queue_tick(16384, -16384);
    queue_tick(-16384, 16384);

    for (int ph = 0; ph < 8; ph++) begin
      next_setting(pick_gain(), pick_gain());
      write_reg(cfg_idx_t'($urandom_range(2, 255)), cfg_data_t'($urandom));
      repeat (125) queue_tick(pick_drive(), pick_drive());
    end

    // full rate: no gaps, no stalls
    wait_drained();
    no_idle = 1'b1;
    next_setting(pick_gain(), pick_gain());
    repeat (60) queue_tick(pick_drive(), pick_drive());
    wait_drained();
    no_idle = 1'b0;

    next_setting(pick_gain(), pick_gain());
    repeat (60) queue_tick(pick_drive(), pick_drive());

    wait_drained();
    repeat (CORDIC_STEPS + 24) @(posedge clk);
    if (pose_errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/odo_pkg.sv
hdl/odo_if.sv
hdl/odo_mul.sv
hdl/odo_cordic.sv
hdl/differential_drive_odometry_unit.sv
test/testbench.sv
